### design/hlm_pkg.sv
// Shared types and constants of the heartbeat liveness monitor.
// Holds action codes, register indexes, reset values and the beat structs.
// Has no dependencies.
package hlm_pkg;

   localparam logic [1:0] ACT_POLL  = 2'd0;
   localparam logic [1:0] ACT_INIT  = 2'd1;
   localparam logic [1:0] ACT_REARM = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] CSR_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE = 2'd1;
   localparam logic [1:0] CSR_GRACE    = 2'd2;

   localparam logic [31:0] TIMEOUT_RESET  = 32'd3000;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [31:0] GRACE_RESET    = 32'd2000;

   typedef struct packed {
      logic [31:0] timeout_ms;
      logic [15:0] debounce_ms;
      logic [31:0] grace_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        pin_level;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic        heartbeat_ok;
      logic        alive_flag;
      logic        signal_seen;
      logic [31:0] period_ms;
      logic [31:0] age_ms;
   } result_type;

endpackage

### design/heartbeat_liveness_monitor_core.sv
// Top level of the heartbeat liveness monitor: input register, update logic,
// result register and configuration port. Depends on hlm_pkg, hlm_csr and hlm_step.
//
// The monitor takes one request beat per clock cycle while the result register
// can drain, and returns exactly one response beat for each, in order. A
// request is held in the input register, and its response is then held in the
// result register and presented on the response port. The rate of one beat
// per cycle is set by the state update, which is done in a single pass between
// the input register and the result register. The response register lets a
// new request be taken while a finished response still waits.
// Configuration writes are always ready and should be issued only while no
// request is in flight.
module heartbeat_liveness_monitor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic        req_pin_level,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_heartbeat_ok,
   output logic        rsp_alive_flag,
   output logic        rsp_signal_seen,
   output logic [31:0] rsp_period_ms,
   output logic [31:0] rsp_age_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   hlm_pkg::cfg_type    cfg;
   hlm_pkg::item_type   in_ff;
   hlm_pkg::result_type result;
   hlm_pkg::result_type out_ff;
   logic                in_valid_ff, in_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                advance;
   logic                req_take;

   hlm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hlm_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (in_ff),
      .result  (result)
   );

   // The held beat moves on when the result register is empty or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.action    <= req_action;
         in_ff.pin_level <= req_pin_level;
         in_ff.now_ms    <= req_now_ms;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_heartbeat_ok = out_ff.heartbeat_ok;
   assign rsp_alive_flag   = out_ff.alive_flag;
   assign rsp_signal_seen  = out_ff.signal_seen;
   assign rsp_period_ms    = out_ff.period_ms;
   assign rsp_age_ms       = out_ff.age_ms;

   // Alive is only ever set together with the signal flag.
   a_alive_has_signal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_alive_flag || rsp_signal_seen))
      else $error("alive reported without a seen signal");

   a_ok_has_signal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_heartbeat_ok || rsp_signal_seen))
      else $error("heartbeat ok reported without a seen signal");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall))
      else $error("request stalled while the result register can drain");

endmodule

### design/hlm_csr.sv
// Configuration registers of the heartbeat liveness monitor.
// Depends on hlm_pkg for register indexes, reset values and cfg_type.
module hlm_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output hlm_pkg::cfg_type cfg
);

   logic [31:0] timeout_ff;
   logic [15:0] debounce_ff;
   logic [31:0] grace_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= hlm_pkg::TIMEOUT_RESET;
         debounce_ff <= hlm_pkg::DEBOUNCE_RESET;
         grace_ff    <= hlm_pkg::GRACE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hlm_pkg::CSR_TIMEOUT:  timeout_ff  <= csr_wdata;
            hlm_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata[15:0];
            hlm_pkg::CSR_GRACE:    grace_ff    <= csr_wdata;
            default: begin
               // Writes to an unmapped index are dropped.
            end
         endcase
      end
   end

   assign cfg.timeout_ms  = timeout_ff;
   assign cfg.debounce_ms = debounce_ff;
   assign cfg.grace_ms    = grace_ff;

endmodule

### design/hlm_step.sv
// Monitor state and the single-pass update logic for one beat.
// Depends on hlm_pkg for action codes and the cfg, item and result structs.
module hlm_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  hlm_pkg::cfg_type    cfg,
   input  hlm_pkg::item_type   item,
   output hlm_pkg::result_type result
);

   logic        last_level_ff, last_level_in;
   logic [31:0] last_edge_ff, last_edge_in;
   logic [31:0] prev_edge_ff, prev_edge_in;
   logic [31:0] period_ff, period_in;
   logic        alive_ff, alive_in;
   logic        has_signal_ff, has_signal_in;
   logic [31:0] window_ff, window_in;
   logic [31:0] debounce_edge_ff, debounce_edge_in;

   logic        changed;
   logic        bounced;
   logic        edge_ok;
   logic        in_grace;
   logic        timed_out;
   logic        ok;
   logic [31:0] since_debounce;
   logic [31:0] since_window;
   logic [31:0] poll_age;

   always_comb begin
      changed        = item.pin_level != last_level_ff;
      since_debounce = item.now_ms - debounce_edge_ff;
      bounced        = changed && (since_debounce < {16'd0, cfg.debounce_ms});
      edge_ok        = changed && !bounced;
      since_window   = item.now_ms - window_ff;
      in_grace       = since_window < cfg.grace_ms;

      last_level_in    = last_level_ff;
      last_edge_in     = last_edge_ff;
      prev_edge_in     = prev_edge_ff;
      period_in        = period_ff;
      alive_in         = alive_ff;
      has_signal_in    = has_signal_ff;
      window_in        = window_ff;
      debounce_edge_in = debounce_edge_ff;
      ok               = 1'b0;

      // The age seen by the timeout check is taken against the edge time
      // after this poll, so an accepted edge gives an age of zero.
      poll_age  = edge_ok ? 32'd0 : (item.now_ms - last_edge_ff);
      timed_out = poll_age > cfg.timeout_ms;

      case (item.action)
         hlm_pkg::ACT_POLL: begin
            if (edge_ok) begin
               debounce_edge_in = item.now_ms;
               last_level_in    = item.pin_level;
               prev_edge_in     = last_edge_ff;
               last_edge_in     = item.now_ms;
               if (item.now_ms > last_edge_ff) begin
                  period_in = item.now_ms - last_edge_ff;
               end
               alive_in      = 1'b1;
               has_signal_in = 1'b1;
            end
            if (bounced) begin
               ok = alive_ff;
            end else if (!has_signal_in) begin
               ok = 1'b0;
            end else if (in_grace) begin
               ok = alive_in;
            end else if (timed_out) begin
               alive_in = 1'b0;
               ok       = 1'b0;
            end else begin
               ok = 1'b1;
            end
         end
         hlm_pkg::ACT_INIT: begin
            last_level_in = item.pin_level;
            last_edge_in  = item.now_ms;
            prev_edge_in  = item.now_ms;
            window_in     = item.now_ms;
            alive_in      = 1'b0;
            has_signal_in = 1'b0;
         end
         hlm_pkg::ACT_REARM: begin
            last_level_in = item.pin_level;
            last_edge_in  = item.now_ms;
            prev_edge_in  = item.now_ms;
            window_in     = item.now_ms;
         end
         default: begin
            alive_in      = 1'b0;
            has_signal_in = 1'b0;
         end
      endcase

      result.heartbeat_ok = ok;
      result.alive_flag   = alive_in;
      result.signal_seen  = has_signal_in;
      result.period_ms    = period_in;
      result.age_ms       = item.now_ms - last_edge_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff    <= 1'b0;
         last_edge_ff     <= 32'd0;
         prev_edge_ff     <= 32'd0;
         period_ff        <= 32'd0;
         alive_ff         <= 1'b0;
         has_signal_ff    <= 1'b0;
         window_ff        <= 32'd0;
         debounce_edge_ff <= 32'd0;
      end else if (advance) begin
         last_level_ff    <= last_level_in;
         last_edge_ff     <= last_edge_in;
         prev_edge_ff     <= prev_edge_in;
         period_ff        <= period_in;
         alive_ff         <= alive_in;
         has_signal_ff    <= has_signal_in;
         window_ff        <= window_in;
         debounce_edge_ff <= debounce_edge_in;
      end
   end

endmodule
